@@ rtl/ipacl_pkg.sv @@
// Shared types, codes and helpers for the IPv4 prefix allow/deny filter.
`timescale 1ns / 1ps
`default_nettype none

package ipacl_pkg;

    localparam int RULE_DEPTH_DEF = 16;

    localparam int ADDR_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic LIST_ALLOW = 1'b0;
    localparam logic LIST_DENY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOWED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DENIED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_MASK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXISTS      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd6;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
    } rule_t;

    typedef struct packed {
        logic prefix_hit;
        logic exact_hit;
    } match_t;

    // Leading-ones mask; lengths of 32 and above give all ones.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        prefix_mask = ~({ADDR_W{1'b1}} >> plen);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipacl_match.sv @@
// Shared compare unit: prefix match and exact rule match of one stored rule.
`timescale 1ns / 1ps
`default_nettype none

module ipacl_match (
    input  var ipacl_pkg::rule_t           rule,
    input  wire [ipacl_pkg::ADDR_W-1:0]    key_addr,
    input  wire [ipacl_pkg::PLEN_W-1:0]    key_plen,
    output ipacl_pkg::match_t              result
);

    logic [ipacl_pkg::ADDR_W-1:0] mask;

    always_comb begin
        mask              = ipacl_pkg::prefix_mask(rule.plen);
        result.prefix_hit = ((rule.addr & mask) == (key_addr & mask));
        result.exact_hit  = (rule.addr == key_addr) && (rule.plen == key_plen);
    end

endmodule

`default_nettype wire

@@ rtl/ipacl_table.sv @@
// Rule memory holding both tables, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ipacl_table #(
    parameter int RULE_DEPTH = ipacl_pkg::RULE_DEPTH_DEF,
    parameter int AW         = $clog2(2 * RULE_DEPTH)
) (
    input  wire                 aclk,
    input  wire                 we,
    input  wire [AW-1:0]        waddr,
    input  var ipacl_pkg::rule_t wdata,
    input  wire                 re,
    input  wire [AW-1:0]        raddr,
    output ipacl_pkg::rule_t    rdata
);

    // Allow rules sit in the lower half, deny rules in the upper half.
    ipacl_pkg::rule_t mem [2*RULE_DEPTH];
    ipacl_pkg::rule_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/ip_prefix_allow_deny_filter_core.sv @@
// Top level of the IPv4 prefix allow/deny filter: sequencer, counts and result register.
//
// One s_ transaction carries an operation (check, add or remove), a table
// select, an IPv4 address and a prefix length; each produces exactly one
// status transaction on the m_ channel. s_ready is high only while the
// sequencer is idle. Rules live in one memory with a registered read port,
// and a single compare unit walks the stored rules one per cycle.
// A check scans the allow table and then, after an allow hit, the deny
// table; an empty allow table skips its scan. An add scans its table for
// a duplicate; a bad mask or an unused operation goes straight to the
// status. A remove scans for the rule and then moves each following rule
// up one place. The scans run through the memory read port. A new
// transaction is accepted only once the previous status has been placed
// in the output register.
// A finished status waits in the output register; if the receiver stalls,
// a new transaction is still accepted and processed, and its status waits
// until the register frees. Reset empties both tables and drops any
// pending status; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ip_prefix_allow_deny_filter_core #(
    parameter int RULE_DEPTH = ipacl_pkg::RULE_DEPTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [ipacl_pkg::OP_W-1:0]        s_operation,
    input  wire                              s_list_select,
    input  wire [ipacl_pkg::ADDR_W-1:0]      s_ip_address,
    input  wire [ipacl_pkg::PLEN_W-1:0]      s_prefix_len,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [ipacl_pkg::STATUS_W-1:0]   m_status
);

    localparam int CW   = $clog2(RULE_DEPTH + 1);
    localparam int IDXW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int AW   = $clog2(2 * RULE_DEPTH);

    localparam logic [CW-1:0] DEPTH_C = CW'(RULE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHR  = 3'd2;
    localparam logic [2:0] S_SHW  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [ipacl_pkg::OP_W-1:0]        op_reg, op_next;
    logic                              tsel_reg, tsel_next;
    logic [ipacl_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [ipacl_pkg::PLEN_W-1:0]      plen_reg, plen_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic                              cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]                     cmp_idx_reg, cmp_idx_next;
    logic [ipacl_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [CW-1:0]                     allow_count_reg, allow_count_next;
    logic [CW-1:0]                     deny_count_reg, deny_count_next;
    logic                              m_valid_reg, m_valid_next;
    logic [ipacl_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;

    logic                              mem_we, mem_re;
    logic [AW-1:0]                     mem_waddr, mem_raddr;
    ipacl_pkg::rule_t                  mem_wdata, mem_rdata;
    ipacl_pkg::match_t                 cmp;

    logic [CW-1:0]                     tcount;
    logic [CW-1:0]                     idx_inc;
    logic                              issue, hit;

    function automatic logic [AW-1:0] rule_addr(input logic sel, input logic [IDXW-1:0] idx);
        rule_addr = sel ? (AW'(RULE_DEPTH) + AW'(idx)) : AW'(idx);
    endfunction

    ipacl_table #(
        .RULE_DEPTH (RULE_DEPTH),
        .AW         (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ipacl_match u_match (
        .rule     (mem_rdata),
        .key_addr (addr_reg),
        .key_plen (plen_reg),
        .result   (cmp)
    );

    assign tcount  = tsel_reg ? deny_count_reg : allow_count_reg;
    assign idx_inc = idx_reg + CW'(1);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        tsel_next        = tsel_reg;
        addr_next        = addr_reg;
        plen_next        = plen_reg;
        idx_next         = idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        status_next      = status_reg;
        allow_count_next = allow_count_reg;
        deny_count_next  = deny_count_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        mem_we           = 1'b0;
        mem_waddr        = rule_addr(tsel_reg, tcount[IDXW-1:0]);
        mem_wdata        = '{addr: addr_reg, plen: plen_reg};
        mem_re           = 1'b0;
        mem_raddr        = rule_addr(tsel_reg, idx_reg[IDXW-1:0]);
        issue            = 1'b0;
        hit              = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    addr_next    = s_ip_address;
                    plen_next    = s_prefix_len;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    priority if (s_operation == ipacl_pkg::OP_CHECK) begin
                        tsel_next  = (allow_count_reg == '0) ? ipacl_pkg::LIST_DENY
                                                             : ipacl_pkg::LIST_ALLOW;
                        state_next = S_SCAN;
                    end else if (s_operation == ipacl_pkg::OP_ADD ||
                                 s_operation == ipacl_pkg::OP_REMOVE) begin
                        tsel_next = s_list_select;
                        if (s_prefix_len > ipacl_pkg::PLEN_MAX) begin
                            status_next = ipacl_pkg::ST_BAD_MASK;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        status_next = ipacl_pkg::ST_OK;
                        state_next  = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                // Reads run one entry ahead of the compare.
                issue        = (idx_reg < tcount);
                mem_re       = issue;
                cmp_vld_next = issue;
                cmp_idx_next = idx_reg;
                if (issue) begin
                    idx_next = idx_inc;
                end
                hit = cmp_vld_reg &&
                      ((op_reg == ipacl_pkg::OP_CHECK) ? cmp.prefix_hit : cmp.exact_hit);
                if (hit || (!issue && !cmp_vld_reg)) begin
                    cmp_vld_next = 1'b0;
                    idx_next     = '0;
                    if (op_reg == ipacl_pkg::OP_CHECK) begin
                        if (tsel_reg == ipacl_pkg::LIST_ALLOW) begin
                            if (hit) begin
                                tsel_next = ipacl_pkg::LIST_DENY;
                            end else begin
                                status_next = ipacl_pkg::ST_NOT_ALLOWED;
                                state_next  = S_DONE;
                            end
                        end else begin
                            status_next = hit ? ipacl_pkg::ST_DENIED : ipacl_pkg::ST_OK;
                            state_next  = S_DONE;
                        end
                    end else if (op_reg == ipacl_pkg::OP_ADD) begin
                        state_next = S_DONE;
                        if (hit) begin
                            status_next = ipacl_pkg::ST_EXISTS;
                        end else if (tcount >= DEPTH_C) begin
                            status_next = ipacl_pkg::ST_FULL;
                        end else begin
                            status_next = ipacl_pkg::ST_OK;
                            mem_we      = 1'b1;
                            if (tsel_reg) begin
                                deny_count_next = deny_count_reg + CW'(1);
                            end else begin
                                allow_count_next = allow_count_reg + CW'(1);
                            end
                        end
                    end else begin
                        if (hit) begin
                            idx_next   = cmp_idx_reg;
                            state_next = S_SHR;
                        end else begin
                            status_next = ipacl_pkg::ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                    end
                end
            end

            S_SHR: begin
                if (idx_inc < tcount) begin
                    mem_re     = 1'b1;
                    mem_raddr  = rule_addr(tsel_reg, idx_inc[IDXW-1:0]);
                    state_next = S_SHW;
                end else begin
                    if (tsel_reg) begin
                        deny_count_next = deny_count_reg - CW'(1);
                    end else begin
                        allow_count_next = allow_count_reg - CW'(1);
                    end
                    status_next = ipacl_pkg::ST_OK;
                    state_next  = S_DONE;
                end
            end

            S_SHW: begin
                // Move the following rule up one place to close the gap.
                mem_we     = 1'b1;
                mem_waddr  = rule_addr(tsel_reg, idx_reg[IDXW-1:0]);
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = S_SHR;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cmp_vld_reg     <= 1'b0;
            allow_count_reg <= '0;
            deny_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cmp_vld_reg     <= cmp_vld_next;
            allow_count_reg <= allow_count_next;
            deny_count_reg  <= deny_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        tsel_reg     <= tsel_next;
        addr_reg     <= addr_next;
        plen_reg     <= plen_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
    end

endmodule

`default_nettype wire

@@ rtl/ipacl_checker.sv @@
// Port-level assertions for the prefix filter core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ipacl_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [ipacl_pkg::STATUS_W-1:0]    m_status
);

    // One transaction at a time: the sequencer is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready stayed high after an input transaction");

    // A status never follows its input transaction in the very next cycle.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared one cycle after acceptance");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ipacl_pkg::ST_FULL))
        else $error("status code out of range");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("stalled result changed or dropped");

endmodule

bind ip_prefix_allow_deny_filter_core ipacl_checker u_ipacl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status)
);

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the IPv4 prefix allow/deny filter core: predicted status checking.
`timescale 1ns / 1ps

module tb;

    typedef logic [ipacl_pkg::OP_W-1:0]     op_t;
    typedef logic [ipacl_pkg::ADDR_W-1:0]   addr_t;
    typedef logic [ipacl_pkg::PLEN_W-1:0]   plen_t;
    typedef logic [ipacl_pkg::STATUS_W-1:0] status_t;

    localparam int DEPTH = ipacl_pkg::RULE_DEPTH_DEF;
    localparam int POOL_SIZE = 28;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam op_t OP_UNUSED = 2'd3;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    op_t     s_operation;
    logic    s_list_select;
    addr_t   s_ip_address;
    plen_t   s_prefix_len;
    logic    m_valid;
    logic    m_ready;
    status_t m_status;

    // Shadow copy of both rule tables, indexed by LIST_ALLOW / LIST_DENY.
    ipacl_pkg::rule_t acl_rules[2][DEPTH];
    int               acl_count[2];
    ipacl_pkg::rule_t addr_pool[POOL_SIZE];

    status_t pending_status_q[$];
    int src_idle_pct;
    int sink_idle_pct;
    int fail_cnt;
    int cycle_cnt;

    ip_prefix_allow_deny_filter_core #(
        .RULE_DEPTH(DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_list_select(s_list_select),
        .s_ip_address(s_ip_address),
        .s_prefix_len(s_prefix_len),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic addr_t lead_mask(input plen_t plen);
        if (plen == 0)
            return '0;
        else if (plen >= ipacl_pkg::PLEN_MAX)
            return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (ipacl_pkg::ADDR_W - plen);
    endfunction

    function automatic bit table_hit(input logic sel, input addr_t addr);
        addr_t m;
        for (int i = 0; i < acl_count[sel]; i++) begin
            m = lead_mask(acl_rules[sel][i].plen);
            if ((acl_rules[sel][i].addr & m) == (addr & m))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int rule_index(input logic sel, input addr_t addr, input plen_t plen);
        for (int i = 0; i < acl_count[sel]; i++)
            if (acl_rules[sel][i].addr == addr && acl_rules[sel][i].plen == plen)
                return i;
        return -1;
    endfunction

    // Applies one transaction to the shadow tables and returns its status.
    function automatic status_t acl_apply(input op_t op, input logic sel,
                                          input addr_t addr, input plen_t plen);
        status_t st;
        int pos;
        st = ipacl_pkg::ST_OK;
        case (op)
            ipacl_pkg::OP_CHECK: begin
                if (acl_count[ipacl_pkg::LIST_ALLOW] != 0 &&
                    !table_hit(ipacl_pkg::LIST_ALLOW, addr))
                    st = ipacl_pkg::ST_NOT_ALLOWED;
                else if (table_hit(ipacl_pkg::LIST_DENY, addr))
                    st = ipacl_pkg::ST_DENIED;
            end
            ipacl_pkg::OP_ADD: begin
                if (plen > ipacl_pkg::PLEN_MAX) begin
                    st = ipacl_pkg::ST_BAD_MASK;
                end else if (rule_index(sel, addr, plen) >= 0) begin
                    st = ipacl_pkg::ST_EXISTS;
                end else if (acl_count[sel] >= DEPTH) begin
                    st = ipacl_pkg::ST_FULL;
                end else begin
                    acl_rules[sel][acl_count[sel]].addr = addr;
                    acl_rules[sel][acl_count[sel]].plen = plen;
                    acl_count[sel]++;
                end
            end
            ipacl_pkg::OP_REMOVE: begin
                pos = rule_index(sel, addr, plen);
                if (plen > ipacl_pkg::PLEN_MAX) begin
                    st = ipacl_pkg::ST_BAD_MASK;
                end else if (pos < 0) begin
                    st = ipacl_pkg::ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i + 1 < acl_count[sel]; i++)
                        acl_rules[sel][i] = acl_rules[sel][i + 1];
                    acl_count[sel]--;
                end
            end
            default: ;
        endcase
        return st;
    endfunction

    // Mostly addresses that fall inside a stored rule, some just outside it.
    function automatic addr_t near_address();
        logic sel;
        ipacl_pkg::rule_t r;
        addr_t m;
        addr_t addr;
        sel = 1'($urandom_range(0, 1));
        if (acl_count[sel] == 0 || $urandom_range(0, 3) == 0)
            return $urandom;
        r = acl_rules[sel][$urandom_range(0, acl_count[sel] - 1)];
        m = lead_mask(r.plen);
        addr = (r.addr & m) | ($urandom & ~m);
        if (r.plen != 0 && $urandom_range(0, 3) == 0)
            addr[ipacl_pkg::ADDR_W - 1 - $urandom_range(0, r.plen - 1)] ^= 1'b1;
        return addr;
    endfunction

    task automatic send_item(input op_t op, input logic sel, input addr_t addr,
                             input plen_t plen);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_list_select <= sel;
        s_ip_address  <= addr;
        s_prefix_len  <= plen;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_status_q.push_back(acl_apply(op, sel, addr, plen));
    endtask

    task automatic test_directed();
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'h0000_0000, 6'd0);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_DENY, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_UNUSED, ipacl_pkg::LIST_DENY, 32'hFFFF_FFFF, 6'd63);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd33);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_DENY, 32'h0A00_0000, 6'd63);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd63);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd8);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd8);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd8);
        // Same network under the mask, but the full address differs: not a duplicate.
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_ALLOW, 32'h0A01_0000, 6'd8);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'h0AC8_0304, 6'd0);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'h0B00_0001, 6'd0);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_DENY, 32'h0A14_0000, 6'd16);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'h0A14_0505, 6'd0);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_DENY, 32'hFFFF_FFFF, 6'd32);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'hFFFF_FFFF, 6'd0);
        send_item(ipacl_pkg::OP_ADD, ipacl_pkg::LIST_ALLOW, 32'h0000_0000, 6'd0);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'hFFFF_FFFF, 6'd0);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_DENY, 32'h0000_0000, 6'd40);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd16);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd8);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0A00_0000, 6'd8);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0000_0000, 6'd0);
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_ALLOW, 32'h0A01_0000, 6'd8);
        send_item(ipacl_pkg::OP_CHECK, ipacl_pkg::LIST_ALLOW, 32'h0B00_0001, 6'd0);
    endtask

    task automatic test_table_fill();
        ipacl_pkg::rule_t r;
        logic sel;
        for (int t = 0; t < 2; t++) begin
            sel = t[0];
            // Hold off until the block has answered everything in flight.
            s_valid <= 1'b0;
            while (pending_status_q.size() != 0)
                @(posedge aclk);
            while (acl_count[sel] < DEPTH)
                send_item(ipacl_pkg::OP_ADD, sel, $urandom, plen_t'($urandom_range(0, 32)));
            send_item(ipacl_pkg::OP_ADD, sel, $urandom, 6'd24);
            r = acl_rules[sel][DEPTH - 1];
            send_item(ipacl_pkg::OP_ADD, sel, r.addr, r.plen);
            send_item(ipacl_pkg::OP_ADD, sel, $urandom, 6'd40);
        end
        repeat (6)
            send_item(ipacl_pkg::OP_CHECK, 1'($urandom_range(0, 1)), near_address(),
                      plen_t'($urandom_range(0, 63)));
        while (acl_count[ipacl_pkg::LIST_ALLOW] + acl_count[ipacl_pkg::LIST_DENY] != 0) begin
            sel = (acl_count[ipacl_pkg::LIST_ALLOW] == 0) ? ipacl_pkg::LIST_DENY :
                  (acl_count[ipacl_pkg::LIST_DENY] == 0) ? ipacl_pkg::LIST_ALLOW :
                  1'($urandom_range(0, 1));
            r = acl_rules[sel][$urandom_range(0, acl_count[sel] - 1)];
            send_item(ipacl_pkg::OP_REMOVE, sel, r.addr, r.plen);
        end
        send_item(ipacl_pkg::OP_REMOVE, ipacl_pkg::LIST_DENY, $urandom, 6'd32);
    endtask

    task automatic test_random(input int n_items);
        int kind;
        int add_bias;
        logic sel;
        ipacl_pkg::rule_t r;
        for (int i = 0; i < n_items; i++) begin
            // Draw a new add bias every 50 items so stretches fill or drain and the tables hit full.
            if (i % 50 == 0)
                add_bias = $urandom_range(15, 45);
            kind = $urandom_range(0, 99);
            sel = 1'($urandom_range(0, 1));
            if (kind < 35) begin
                send_item(ipacl_pkg::OP_CHECK, sel, near_address(),
                          plen_t'($urandom_range(0, 63)));
            end else if (kind < 35 + add_bias) begin
                r = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(ipacl_pkg::OP_ADD, sel, r.addr, r.plen);
            end else if (kind < 92) begin
                if (acl_count[sel] != 0 && $urandom_range(0, 3) != 0)
                    r = acl_rules[sel][$urandom_range(0, acl_count[sel] - 1)];
                else
                    r = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(ipacl_pkg::OP_REMOVE, sel, r.addr, r.plen);
            end else begin
                case ($urandom_range(0, 2))
                    0: send_item(OP_UNUSED, sel, $urandom, plen_t'($urandom_range(0, 63)));
                    1: send_item(op_t'($urandom_range(1, 2)), sel, $urandom,
                                 plen_t'($urandom_range(33, 63)));
                    default: send_item(op_t'($urandom_range(0, 3)), sel, $urandom,
                                       plen_t'($urandom_range(0, 63)));
                endcase
            end
        end
    endtask

    // Result side: random back-pressure and in-order comparison.
    initial begin
        status_t want_status;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_status_q.size() == 0) begin
                    $error("status: unexpected transaction, actual %0d", m_status);
                    fail_cnt++;
                end else begin
                    want_status = pending_status_q.pop_front();
                    if (m_status !== want_status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want_status, m_status);
                        fail_cnt++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = ipacl_pkg::OP_CHECK;
        s_list_select = ipacl_pkg::LIST_ALLOW;
        s_ip_address  = '0;
        s_prefix_len  = '0;
        src_idle_pct  = 23;
        sink_idle_pct = 47;
        fail_cnt      = 0;
        acl_count[ipacl_pkg::LIST_ALLOW] = 0;
        acl_count[ipacl_pkg::LIST_DENY]  = 0;
        // Odd pool entries reuse the previous address with a freshly drawn length.
        for (int k = 0; k < POOL_SIZE; k++) begin
            addr_pool[k].addr = (k % 2 == 1) ? addr_pool[k - 1].addr : $urandom;
            case ($urandom_range(0, 9))
                0: addr_pool[k].plen = 6'd0;
                1: addr_pool[k].plen = 6'd32;
                default: addr_pool[k].plen = plen_t'($urandom_range(1, 31));
            endcase
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_table_fill();
        test_random(270);
        src_idle_pct  = 47;
        sink_idle_pct = 23;
        test_random(270);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random(270);

        s_valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
